// ----- hdl/assert_macros.svh -----
// Shared assertion forms: clocked, disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/cfh_pkg.sv -----
package cfh_pkg;

	localparam int CHUNK_W = 25;
	localparam int HASH_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] IDX_CHUNK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_OFFSET_BASIS = 2'd1;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = 25'd1048576;
	localparam logic [HASH_W-1:0] STD_BASIS = 64'hcbf29ce484222325;
	localparam logic [HASH_W-1:0] GOLDEN_MIX = 64'h9e3779b97f4a7c15;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_bytes;
		logic               reload;
		logic [HASH_W-1:0]  reload_basis;
		logic [HASH_W-1:0]  offset_basis;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] hash;
	} result_t;

	// multiply by the FNV-64 prime 2^40 + 0x1b3, as shifts and adds
	function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
		mul_prime = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
	endfunction

endpackage

// ----- hdl/cfh_cfg.sv -----
module cfh_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [cfh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfh_pkg::HASH_W-1:0]          cfg_data,
	output cfh_pkg::cfg_t                       cfg
);
	import cfh_pkg::*;

	logic [CHUNK_W-1:0] chunk_bytes_q;
	logic [HASH_W-1:0]  basis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= CHUNK_RESET;
			basis_q       <= STD_BASIS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				IDX_CHUNK_BYTES: begin
					chunk_bytes_q <= cfg_data[CHUNK_W-1:0];
				end
				IDX_OFFSET_BASIS: begin
					basis_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// a basis write also restarts the file in progress
	assign cfg.chunk_bytes  = chunk_bytes_q;
	assign cfg.offset_basis = basis_q;
	assign cfg.reload       = cfg_wr_en && (cfg_index == IDX_OFFSET_BASIS);
	assign cfg.reload_basis = cfg_data;

endmodule

// ----- hdl/cfh_core.sv -----
module cfh_core (
	input  logic             clk,
	input  logic             arst_n,
	input  cfh_pkg::cfg_t    cfg,
	input  logic             step,
	input  cfh_pkg::item_t   item,
	output cfh_pkg::result_t result
);
	import cfh_pkg::*;

	logic [HASH_W-1:0]  file_q;
	logic [HASH_W-1:0]  chunk_q;
	logic [CHUNK_W-1:0] fill_q;

	logic [HASH_W-1:0]  chunk_nx;
	logic [CHUNK_W-1:0] fill_nx;
	logic               fold;
	logic [HASH_W-1:0]  file_nx;

	always_comb begin
		if (item.has_byte) begin
			chunk_nx = mul_prime(chunk_q ^ {{(HASH_W-8){1'b0}}, item.data_byte});
			fill_nx  = fill_q + {{(CHUNK_W-1){1'b0}}, 1'b1};
		end else begin
			chunk_nx = chunk_q;
			fill_nx  = fill_q;
		end
		// full chunk (or fill wrapped to zero), or partial chunk at end of file;
		// a fold clears the fill, so at most one fold per word
		fold = (item.has_byte && ((fill_nx >= cfg.chunk_bytes) || (fill_nx == '0)))
			|| (item.end_of_file && (fill_nx != '0));
		file_nx = fold ? (chunk_nx ^ (file_q + GOLDEN_MIX)) : file_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_q  <= STD_BASIS;
			chunk_q <= STD_BASIS;
			fill_q  <= '0;
		end else if (cfg.reload) begin
			file_q  <= cfg.reload_basis;
			chunk_q <= cfg.reload_basis;
			fill_q  <= '0;
		end else if (step) begin
			if (item.end_of_file) begin
				file_q  <= cfg.offset_basis;
				chunk_q <= cfg.offset_basis;
				fill_q  <= '0;
			end else if (fold) begin
				file_q  <= file_nx;
				chunk_q <= cfg.offset_basis;
				fill_q  <= '0;
			end else begin
				chunk_q <= chunk_nx;
				fill_q  <= fill_nx;
			end
		end
	end

	assign result.done = step && item.end_of_file;
	assign result.hash = file_nx;

endmodule

// ----- hdl/chunked_fnv1a64_file_hash_unit.sv -----
// Chunked FNV-1a 64 file hash. One byte word enters per cycle unless in_stall
// holds it; its hash step (xor, multiply by the sparse FNV prime as shift-add,
// chunk fold) is combinational between the input register and the running-hash
// state, so the sustained rate is one word per clock while nothing stalls. A
// word carrying end_of_file goes through the input register, and its hash is
// registered as file_hash when the result register is free. in_stall rises
// only when an end-of-file word waits behind a stalled result. Configuration
// writes are registered; an offset basis write restarts the file in progress.
module chunked_fnv1a64_file_hash_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cfh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfh_pkg::HASH_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              has_byte,
	input  logic                              end_of_file,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cfh_pkg::HASH_W-1:0]        file_hash
);
	import cfh_pkg::*;

	cfg_t    cfg;
	result_t result;

	item_t             item_s1;
	logic              valid_s1;
	logic              step;
	logic              out_valid_q;
	logic [HASH_W-1:0] file_hash_q;

	cfh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// only an end-of-file word needs room in the result register
	assign step     = valid_s1 && !(item_s1.end_of_file && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.data_byte   <= data_byte;
			item_s1.has_byte    <= has_byte;
			item_s1.end_of_file <= end_of_file;
		end
	end

	cfh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.done) begin
			file_hash_q <= result.hash;
		end
	end

	assign out_valid = out_valid_q;
	assign file_hash = file_hash_q;

endmodule

// ----- hdl/cfh_checker.sv -----
`include "assert_macros.svh"

module cfh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [cfh_pkg::HASH_W-1:0]    file_hash
);

	// a stalled result stays and holds its word
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(file_hash))

	// input backpressure comes only from a stalled result
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// the waiting end-of-file word keeps a result on the output next cycle
	`ASSERT_NEXT(a_stall_result, clk, arst_n, in_stall, out_valid)

endmodule

bind chunked_fnv1a64_file_hash_unit cfh_checker u_cfh_checker (.*);

// ----- bench/tb_chunked_fnv1a64_file_hash_unit.sv -----
`timescale 1ns / 100ps

module tb_chunked_fnv1a64_file_hash_unit;
	import cfh_pkg::*;

	localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
	// basis literal with the dropped digit
	localparam logic [HASH_W-1:0] SHORT_BASIS = 64'd1469598103934665603;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;
	localparam logic [CHUNK_W-1:0] CHUNK_MAX = 25'h1FF_FFFF;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS = 232;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [HASH_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic has_byte = 1'b0;
	logic end_of_file = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [HASH_W-1:0] file_hash;

	chunked_fnv1a64_file_hash_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.file_hash(file_hash)
	);

	item_t pending_words[$];
	logic [HASH_W-1:0] expected_hashes[$];
	item_t next_word;
	logic [HASH_W-1:0] want_hash;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int stream_words = 0;

	// predicted block state
	logic [CHUNK_W-1:0] chunk_len = CHUNK_RESET;
	logic [HASH_W-1:0] basis = STD_BASIS;
	logic [HASH_W-1:0] file_acc = STD_BASIS;
	logic [HASH_W-1:0] chunk_acc = STD_BASIS;
	logic [CHUNK_W-1:0] fill = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void start_new_file();
		file_acc = basis;
		chunk_acc = basis;
		fill = '0;
	endfunction

	function automatic void merge_chunk();
		file_acc = chunk_acc ^ (file_acc + GOLDEN_MIX);
		chunk_acc = basis;
		fill = '0;
	endfunction

	function automatic void absorb_word(input item_t w);
		if (w.has_byte) begin
			chunk_acc = (chunk_acc ^ {56'd0, w.data_byte}) * FNV_PRIME;
			fill = fill + CHUNK_W'(1);
			// a size of zero folds every byte; a wrapped fill folds too
			if (fill >= chunk_len || fill == '0)
				merge_chunk();
		end
		if (w.end_of_file) begin
			if (fill != '0)
				merge_chunk();
			expected_hashes.push_back(file_acc);
			start_new_file();
		end
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic hb, input logic eof);
		item_t w;
		w.data_byte = b;
		w.has_byte = hb;
		w.end_of_file = eof;
		pending_words.push_back(w);
		if (hb || eof)
			stream_words++;
	endfunction

	// one file: random bytes, a few empty words, closed on the last byte or by a bare end
	task automatic queue_file();
		int len;
		int k;
		logic bare_end;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
		bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 19) == 0)
				push_word(8'($urandom), 1'b0, 1'b0);
			push_word(8'($urandom), 1'b1, !bare_end && k == len - 1);
		end
		if (bare_end)
			push_word(8'($urandom), 1'b0, 1'b1);
	endtask

	// returns once nothing is queued, in flight or awaited
	task automatic drain();
		int quiet;
		quiet = 0;
		while (quiet < SETTLE_CYCLES) begin
			@(posedge clk);
			if (pending_words.size() != 0 || in_valid || expected_hashes.size() != 0)
				quiet = 0;
			else
				quiet++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			IDX_CHUNK_BYTES: chunk_len = val[CHUNK_W-1:0];
			IDX_OFFSET_BASIS: begin
				basis = val;
				start_new_file();
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [CHUNK_W-1:0] pick_chunk();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 25'd1;
			2, 3: return 25'($urandom_range(2, 8));
			4, 5: return 25'($urandom_range(9, 40));
			6: return CHUNK_RESET;
			default: return 25'($urandom_range(41, 300));
		endcase
	endfunction

	function automatic logic [HASH_W-1:0] pick_basis();
		case ($urandom_range(0, 5))
			0: return STD_BASIS;
			1: return SHORT_BASIS;
			2: return '0;
			3: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				absorb_word(item_t'{data_byte, has_byte, end_of_file});
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_word.data_byte;
					has_byte <= next_word.has_byte;
					end_of_file <= next_word.end_of_file;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: unexpected file_hash: expected none, got %h", $time, file_hash);
					mismatches++;
				end else begin
					want_hash = expected_hashes.pop_front();
					if (file_hash !== want_hash) begin
						$display("%0t: file_hash: expected %h, got %h", $time, want_hash,
							file_hash);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 13;
		recv_stall_pct = 60;

		// reset settings: empty file, extreme bytes, empty words, bare end
		push_word(8'h00, 1'b0, 1'b1);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b0);
		push_word(8'h5A, 1'b1, 1'b1);
		push_word(8'hC3, 1'b0, 1'b0);
		push_word(8'h61, 1'b1, 1'b0);
		push_word(8'h3C, 1'b0, 1'b0);
		push_word(8'h00, 1'b0, 1'b1);
		drain();

		// size zero, junk above the field
		write_reg(IDX_CHUNK_BYTES, 64'hFFFF_FFFF_FE00_0000);
		write_reg(IDX_OFFSET_BASIS, SHORT_BASIS);
		push_word(8'h01, 1'b1, 1'b0);
		push_word(8'h80, 1'b1, 1'b0);
		push_word(8'h7F, 1'b1, 1'b1);
		drain();

		// leave a file open with three bytes, then shrink the chunk under it
		write_reg(IDX_CHUNK_BYTES, 64'h0000_ABCD_0000_0004);
		push_word(8'h10, 1'b1, 1'b0);
		push_word(8'h20, 1'b1, 1'b0);
		push_word(8'h30, 1'b1, 1'b0);
		drain();
		write_reg(IDX_CHUNK_BYTES, 64'd2);
		push_word(8'h11, 1'b1, 1'b0);
		push_word(8'h22, 1'b1, 1'b1);
		drain();

		// basis write throws away the open file; spare indexes do nothing
		push_word(8'h44, 1'b1, 1'b0);
		push_word(8'h55, 1'b1, 1'b0);
		drain();
		write_reg(IDX_OFFSET_BASIS, '0);
		write_reg(IDX_SPARE_A, '1);
		write_reg(IDX_SPARE_B, 64'hA5A5_5A5A_0F0F_F0F0);
		push_word(8'hAA, 1'b1, 1'b1);
		drain();

		write_reg(IDX_CHUNK_BYTES, {39'd0, CHUNK_MAX});
		push_word(8'h33, 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b1);

		for (phase = 0; phase < 6; phase++) begin
			drain();
			send_gap_pct = (phase < 2) ? 13 : (phase < 4) ? 60 : 0;
			recv_stall_pct = (phase < 2) ? 60 : (phase < 4) ? 13 : 0;
			write_reg(IDX_CHUNK_BYTES, {$urandom(), 7'($urandom()), pick_chunk()});
			if ($urandom_range(0, 1))
				write_reg(IDX_OFFSET_BASIS, pick_basis());
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
					{$urandom(), $urandom()});
			stream_words = 0;
			while (stream_words < PHASE_WORDS)
				queue_file();
			// an open file may carry over into the next register write
			repeat ($urandom_range(0, 3))
				push_word(8'($urandom), 1'b1, 1'b0);
		end
		push_word(8'($urandom), 1'b0, 1'b1);

		drain();
		if (mismatches == 0)
			$display("chunked_fnv1a64_file_hash_unit: match");
		else
			$display("chunked_fnv1a64_file_hash_unit: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("chunked_fnv1a64_file_hash_unit: mismatch");
		$finish;
	end

endmodule
